FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lht_pkg.sv
// ----------------------------------------------------------------------------
// Lock handle table package
// Command and result word types, search token flags, operation and status
// codes, and the controller state type.
// ----------------------------------------------------------------------------
package lht_pkg;

  localparam int KEY_FIELD_W    = 48;
  localparam int HANDLE_FIELD_W = 32;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_REMOVE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]             op;
    logic [KEY_FIELD_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_FIELD_W-1:0] handle;
    logic [1:0]                status;
  } result_t;

  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

FILE: src/lock_handle_table_top.sv
// ----------------------------------------------------------------------------
// Lock handle table
// Dense table of lock keys and handles built as a row of entry cells.
// ----------------------------------------------------------------------------
// A command word (op, key) is taken at a rising edge with start high and
// busy low. Every command gives exactly one result word (handle, status),
// shown for one cycle with done high; the receiver cannot stall it.
// Register and undefined ops answer in the cycle after the command is taken.
// Look up and remove send a search token down the row of cells, one cell
// per cycle; the token is registered at launch and in each cell, and the
// result is registered as the token leaves the last cell. A remove that
// finds its key copies the last live entry, picked up by the same token,
// into the found cell. Register commands can be taken one per cycle; busy
// stays high from a look up or remove until its result is shown.
// Reset clears the live count, the handle counter and the search token;
// entry contents are left as they are and only live entries are compared.
// ----------------------------------------------------------------------------
module lock_handle_table_top #(
  parameter int TABLE_DEPTH  = 256,
  parameter int KEY_WIDTH    = 48,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lht_pkg::cmd_t    cmd,
  output logic             done,
  output lht_pkg::result_t result
);
  import lht_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t                  state;
  state_t                  state_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [HANDLE_WIDTH-1:0] next_handle;
  logic [HANDLE_WIDTH-1:0] next_handle_next;
  logic                    launch;
  logic                    is_remove;
  logic [KEY_WIDTH-1:0]    qkey;
  logic                    done_next;
  result_t                 result_next;

  logic                    accept;
  logic                    scan_op;
  logic                    full;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic [KEY_WIDTH-1:0]    wr_key;
  logic [HANDLE_WIDTH-1:0] wr_handle;

  tok_flags_t              ch_flags       [TABLE_DEPTH+1];
  logic [CNT_W-1:0]        ch_left        [TABLE_DEPTH+1];
  logic [IDX_W-1:0]        ch_pos         [TABLE_DEPTH+1];
  logic [HANDLE_WIDTH-1:0] ch_handle      [TABLE_DEPTH+1];
  logic [KEY_WIDTH-1:0]    ch_last_key    [TABLE_DEPTH+1];
  logic [HANDLE_WIDTH-1:0] ch_last_handle [TABLE_DEPTH+1];

  assign accept  = start && !busy;
  assign scan_op = (cmd.op == OP_LOOKUP) || (cmd.op == OP_REMOVE);
  assign full    = count == CNT_W'(TABLE_DEPTH);

  assign ch_flags[0].valid  = launch;
  assign ch_flags[0].found  = 1'b0;
  assign ch_left[0]         = count;
  assign ch_pos[0]          = '0;
  assign ch_handle[0]       = '0;
  assign ch_last_key[0]     = '0;
  assign ch_last_handle[0]  = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    lht_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .HANDLE_WIDTH(HANDLE_WIDTH),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W),
      .INDEX       (g)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .qkey           (qkey),
      .wr_en          (wr_en),
      .wr_idx         (wr_idx),
      .wr_key         (wr_key),
      .wr_handle      (wr_handle),
      .in_flags       (ch_flags[g]),
      .in_left        (ch_left[g]),
      .in_pos         (ch_pos[g]),
      .in_handle      (ch_handle[g]),
      .in_last_key    (ch_last_key[g]),
      .in_last_handle (ch_last_handle[g]),
      .out_flags      (ch_flags[g+1]),
      .out_left       (ch_left[g+1]),
      .out_pos        (ch_pos[g+1]),
      .out_handle     (ch_handle[g+1]),
      .out_last_key   (ch_last_key[g+1]),
      .out_last_handle(ch_last_handle[g+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && scan_op) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ch_flags[TABLE_DEPTH].valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy               = state != S_IDLE;
    wr_en              = 1'b0;
    wr_idx             = count[IDX_W-1:0];
    wr_key             = KEY_WIDTH'(cmd.key);
    wr_handle          = next_handle;
    count_next         = count;
    next_handle_next   = next_handle;
    done_next          = 1'b0;
    result_next.handle = '0;
    result_next.status = ST_MISSING;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.op)
            OP_REGISTER: begin
              done_next = 1'b1;
              if (full) begin
                result_next.status = ST_FULL;
              end else begin
                wr_en              = 1'b1;
                count_next         = count + CNT_W'(1);
                next_handle_next   = next_handle + HANDLE_WIDTH'(1);
                result_next.handle = HANDLE_FIELD_W'(next_handle);
                result_next.status = ST_OK;
              end
            end
            OP_LOOKUP, OP_REMOVE: begin
              done_next = 1'b0;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ch_flags[TABLE_DEPTH].valid) begin
          done_next = 1'b1;
          if (ch_flags[TABLE_DEPTH].found) begin
            result_next.handle = HANDLE_FIELD_W'(ch_handle[TABLE_DEPTH]);
            result_next.status = ST_OK;
            if (is_remove) begin
              wr_en      = 1'b1;
              wr_idx     = ch_pos[TABLE_DEPTH];
              wr_key     = ch_last_key[TABLE_DEPTH];
              wr_handle  = ch_last_handle[TABLE_DEPTH];
              count_next = count - CNT_W'(1);
            end
          end
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      next_handle <= '0;
      launch      <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      next_handle <= next_handle_next;
      launch      <= accept && scan_op;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      qkey      <= KEY_WIDTH'(cmd.key);
      is_remove <= cmd.op == OP_REMOVE;
    end
  end

endmodule

FILE: src/lht_cell.sv
// ----------------------------------------------------------------------------
// Lock handle table cell
// Holds one table entry and passes the search token on to the next cell,
// marking the first live match and picking up the last live entry.
// ----------------------------------------------------------------------------
module lht_cell #(
  parameter int KEY_WIDTH    = 48,
  parameter int HANDLE_WIDTH = 32,
  parameter int CNT_W        = 9,
  parameter int IDX_W        = 8,
  parameter int INDEX        = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [KEY_WIDTH-1:0]     qkey,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [KEY_WIDTH-1:0]     wr_key,
  input  logic [HANDLE_WIDTH-1:0]  wr_handle,
  input  lht_pkg::tok_flags_t      in_flags,
  input  logic [CNT_W-1:0]         in_left,
  input  logic [IDX_W-1:0]         in_pos,
  input  logic [HANDLE_WIDTH-1:0]  in_handle,
  input  logic [KEY_WIDTH-1:0]     in_last_key,
  input  logic [HANDLE_WIDTH-1:0]  in_last_handle,
  output lht_pkg::tok_flags_t      out_flags,
  output logic [CNT_W-1:0]         out_left,
  output logic [IDX_W-1:0]         out_pos,
  output logic [HANDLE_WIDTH-1:0]  out_handle,
  output logic [KEY_WIDTH-1:0]     out_last_key,
  output logic [HANDLE_WIDTH-1:0]  out_last_handle
);
  import lht_pkg::*;

  logic [KEY_WIDTH-1:0]    cell_key;
  logic [HANDLE_WIDTH-1:0] cell_handle;
  logic                    live;
  logic                    hit;
  logic                    is_last;

  assign live    = in_left != '0;
  assign hit     = in_flags.valid && live && !in_flags.found && (qkey == cell_key);
  assign is_last = in_flags.valid && (in_left == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
      cell_key    <= wr_key;
      cell_handle <= wr_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags <= '0;
    end else begin
      out_flags.valid <= in_flags.valid;
      out_flags.found <= in_flags.found | hit;
    end
  end

  always_ff @(posedge clk) begin
    out_left        <= live ? in_left - CNT_W'(1) : '0;
    out_pos         <= hit ? IDX_W'(INDEX) : in_pos;
    out_handle      <= hit ? cell_handle : in_handle;
    out_last_key    <= is_last ? cell_key : in_last_key;
    out_last_handle <= is_last ? cell_handle : in_last_handle;
  end

endmodule

FILE: src/lht_checker.sv
// ----------------------------------------------------------------------------
// Lock handle table checker
// Port-level assertions on the command and result words, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lht_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input lht_pkg::cmd_t    cmd,
  input logic             done,
  input lht_pkg::result_t result
);
  import lht_pkg::*;

  `ASSERT_IMPLY(a_handle_zero, clk, rst, done && (result.status != ST_OK), result.handle == '0, "handle is not zero on a failed command")
  `ASSERT_IMPLY(a_status_code, clk, rst, done, (result.status == ST_OK) || (result.status == ST_MISSING) || (result.status == ST_FULL), "undefined status code")
  `ASSERT_NEXT(a_register_reply, clk, rst, start && !busy && (cmd.op == OP_REGISTER), done && !busy, "register did not answer in the next cycle")
  `ASSERT_NEXT(a_lookup_busy, clk, rst, start && !busy && (cmd.op == OP_LOOKUP), busy && !done, "look up did not start a scan")
  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy, "result shown while busy")

endmodule

bind lock_handle_table_top lht_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done),
  .result(result)
);
